### hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the shell command lexer
// Character codes, result kinds, operator codes and the beat record that
// travels from the lexer stage to the result buffer.
// ----------------------------------------------------------------------------
package slc_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_LINE  = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_AMP  = 3'd1;
    localparam logic [2:0] OP_BAR  = 3'd2;
    localparam logic [2:0] OP_SEMI = 3'd3;
    localparam logic [2:0] OP_LT   = 3'd4;
    localparam logic [2:0] OP_GT   = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] token_byte;
        logic       operator_token;
        logic       last;
    } result_t;

    // up to two results from one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_AMP:  code = OP_AMP;
            CH_BAR:  code = OP_BAR;
            CH_SEMI: code = OP_SEMI;
            CH_LT:   code = OP_LT;
            CH_GT:   code = OP_GT;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic logic pair_ok(input logic [2:0] first, input logic [2:0] second);
        logic ok;
        unique case (second)
            OP_AMP:  ok = (first == OP_AMP) || (first == OP_LT) || (first == OP_GT);
            OP_BAR:  ok = (first == OP_BAR) || (first == OP_GT);
            OP_SEMI: ok = (first == OP_SEMI);
            OP_LT:   ok = (first == OP_LT);
            OP_GT:   ok = (first == OP_GT) || (first == OP_LT);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

### hdl/slc_lexer.sv
// ----------------------------------------------------------------------------
// slc_lexer: input register and lexer state
// Holds one input byte, classifies it against the quote/escape/operator
// state and hands up to two results to the result buffer in one step.
// ----------------------------------------------------------------------------
module slc_lexer import slc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       buf_ready,
    output logic       push_valid,
    output push_t      push
);

    typedef struct packed {
        logic       esc;
        logic       sq;
        logic       dq;
        logic       op_open;
        logic [2:0] op_first;
        logic       tok_ne;
    } lex_state_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    lex_state_t st_reg;
    lex_state_t st_next;
    logic       consume;
    result_t    res [2];
    logic [1:0] n;

    assign consume    = in_valid_reg && buf_ready;
    assign s_ready    = !in_valid_reg || consume;
    assign push_valid = consume;

    always_comb begin
        logic [7:0] c;
        logic [2:0] code;
        c        = in_byte_reg;
        code     = op_code(c);
        st_next  = st_reg;
        n        = 2'd0;
        res[0]   = '0;
        res[1]   = '0;

        if (c == CH_NUL) begin
            // drop: no results, no state change
        end else if (st_reg.esc || st_reg.sq || st_reg.dq) begin
            if (c == CH_SQ && st_reg.sq && !st_reg.esc) begin
                st_next.sq = 1'b0;
            end else if (c == CH_DQ && st_reg.dq && !st_reg.esc) begin
                st_next.dq = 1'b0;
            end else if (c == CH_LF && st_reg.esc) begin
                st_next.esc = 1'b0;
            end else begin
                res[0]         = '{KIND_BYTE, c, 1'b0, 1'b0};
                n              = 2'd1;
                st_next.tok_ne = 1'b1;
                st_next.esc    = 1'b0;
            end
        end else if (code != OP_NONE) begin
            if (st_reg.op_open && pair_ok(st_reg.op_first, code)) begin
                res[0]           = '{KIND_BYTE, c, 1'b1, 1'b0};
                res[1]           = '{KIND_END_TOKEN, 8'h00, 1'b1, 1'b0};
                n                = 2'd2;
                st_next.tok_ne   = 1'b0;
                st_next.op_open  = 1'b0;
                st_next.op_first = OP_NONE;
            end else begin
                if (st_reg.tok_ne) begin
                    res[0] = '{KIND_END_TOKEN, 8'h00, st_reg.op_open, 1'b0};
                    res[1] = '{KIND_BYTE, c, 1'b1, 1'b0};
                    n      = 2'd2;
                end else begin
                    res[0] = '{KIND_BYTE, c, 1'b1, 1'b0};
                    n      = 2'd1;
                end
                st_next.tok_ne   = 1'b1;
                st_next.op_open  = 1'b1;
                st_next.op_first = code;
            end
        end else if (c == CH_BSL || c == CH_SQ || c == CH_DQ) begin
            if (st_reg.op_open) begin
                res[0]           = '{KIND_END_TOKEN, 8'h00, 1'b1, 1'b0};
                n                = 2'd1;
                st_next.tok_ne   = 1'b0;
                st_next.op_open  = 1'b0;
                st_next.op_first = OP_NONE;
            end
            if (c == CH_BSL) begin
                st_next.esc = 1'b1;
            end else if (c == CH_SQ) begin
                st_next.sq = 1'b1;
            end else begin
                st_next.dq = 1'b1;
            end
        end else if (c == CH_LF) begin
            if (st_reg.tok_ne) begin
                res[0] = '{KIND_END_TOKEN, 8'h00, st_reg.op_open, 1'b0};
                res[1] = '{KIND_END_LINE, 8'h00, 1'b0, 1'b0};
                n      = 2'd2;
            end else begin
                res[0] = '{KIND_END_LINE, 8'h00, 1'b0, 1'b0};
                n      = 2'd1;
            end
            st_next = '0;
        end else if (is_blank(c)) begin
            if (st_reg.tok_ne) begin
                res[0] = '{KIND_END_TOKEN, 8'h00, st_reg.op_open, 1'b0};
                n      = 2'd1;
            end
            st_next.tok_ne   = 1'b0;
            st_next.op_open  = 1'b0;
            st_next.op_first = OP_NONE;
        end else begin
            if (st_reg.op_open) begin
                res[0] = '{KIND_END_TOKEN, 8'h00, 1'b1, 1'b0};
                res[1] = '{KIND_BYTE, c, 1'b0, 1'b0};
                n      = 2'd2;
            end else begin
                res[0] = '{KIND_BYTE, c, 1'b0, 1'b0};
                n      = 2'd1;
            end
            st_next.tok_ne   = 1'b1;
            st_next.op_open  = 1'b0;
            st_next.op_first = OP_NONE;
        end

        // mark the final result of this byte
        if (n == 2'd2) begin
            res[1].last = 1'b1;
        end else if (n == 2'd1) begin
            res[0].last = 1'b1;
        end
    end

    assign push.count = n;
    assign push.r0    = res[0];
    assign push.r1    = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

endmodule

### hdl/slc_out_buf.sv
// ----------------------------------------------------------------------------
// slc_out_buf: two-entry result buffer
// Takes all results of one byte at once and plays them out one beat at a time.
// ----------------------------------------------------------------------------
module slc_out_buf import slc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    input  push_t      push,
    output logic       buf_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_token_byte,
    output logic       m_operator_token,
    output logic       m_last
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    ent_reg [2];
    logic       pop;

    assign m_valid   = (count_reg != 2'd0);
    assign pop       = m_valid && m_ready;
    // empty now, or emptied by this cycle's pop
    assign buf_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);

    assign m_kind           = ent_reg[0].kind;
    assign m_token_byte     = ent_reg[0].token_byte;
    assign m_operator_token = ent_reg[0].operator_token;
    assign m_last           = ent_reg[0].last;

    always_comb begin
        count_next = count_reg;
        if (push_valid) begin
            count_next = push.count;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            ent_reg[0] <= push.r0;
            ent_reg[1] <= push.r1;
        end else if (pop) begin
            ent_reg[0] <= ent_reg[1];
        end
    end

endmodule

### hdl/shell_command_lexer.sv
// ----------------------------------------------------------------------------
// shell_command_lexer: streaming tokeniser for command-line text
// Splits raw command text, one byte a beat, into token bytes, end-of-token
// and end-of-line events.
//
// Usage:
//   Input channel s_valid / s_ready / s_in_byte carries one raw byte a beat.
//   Result channel m_valid / m_ready carries one event a beat: m_kind
//   (0 token byte, 1 end of token, 2 end of line), m_token_byte, the
//   m_operator_token mark and m_last, high on the final event of a byte.
//   An accepted byte passes the input register, then the two-entry result
//   buffer, before its first event shows.
//   Throughput: one byte per cycle when each byte gives at most one event
//   and m_ready is high; a two-event byte holds the input until its first
//   event has left, as the buffer plays out one event a beat. Zero bytes give
//   no event and pass at one a cycle while the buffer has room.
//   Reset (aresetn low, synchronous) empties both registers and clears all
//   quote, escape and operator flags.
//   When the receiver stalls, the buffered events hold on m_* and the input
//   register fills; s_ready drops until the buffer can take the next byte.
// ----------------------------------------------------------------------------
module shell_command_lexer import slc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_token_byte,
    output logic       m_operator_token,
    output logic       m_last
);

    // handover from the lexer stage to the result buffer
    logic  buf_ready;
    logic  push_valid;
    push_t push;

    // classify the held byte and advance the lexer flags
    slc_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .buf_ready  (buf_ready),
        .push_valid (push_valid),
        .push       (push)
    );

    // hold up to two events and stream them out
    slc_out_buf u_out_buf (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .push_valid       (push_valid),
        .push             (push),
        .buf_ready        (buf_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_token_byte     (m_token_byte),
        .m_operator_token (m_operator_token),
        .m_last           (m_last)
    );

endmodule

### hdl/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker: port-level checks for the shell command lexer
// Watches both channels for stall behaviour and the result channel for
// event encoding.
// ----------------------------------------------------------------------------
module slc_checker import slc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_token_byte,
    input logic       m_operator_token,
    input logic       m_last
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_token_byte)
            && $stable(m_operator_token) && $stable(m_last))
        else $error("result beat changed while stalled");

    // events other than token bytes carry no byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_BYTE) |-> (m_token_byte == 8'h00))
        else $error("non-byte event with a byte value");

    // end of line always closes the byte's events and is not an operator
    a_end_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_END_LINE) |-> m_last && !m_operator_token)
        else $error("end-of-line event malformed");

    // a non-final event is always followed by another event of the same byte
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("second event of a byte missing");

endmodule

bind shell_command_lexer slc_checker u_slc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_in_byte        (s_in_byte),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kind           (m_kind),
    .m_token_byte     (m_token_byte),
    .m_operator_token (m_operator_token),
    .m_last           (m_last)
);
